@@ hdl/rcpw_pkg.sv @@
`default_nettype none

package rcpw_pkg;

  // timer and frame geometry
  localparam int TimerWidth = 20;
  localparam logic [31:0] TimerMax = 32'hFFFF_FFFF >> (32 - TimerWidth);
  localparam int FrameBytes = 12;
  localparam int PayloadBytes = FrameBytes - 1;
  localparam int ByteIdxWidth = $clog2(FrameBytes);
  localparam int PhaseWidth = 4;
  localparam logic [PhaseWidth-1:0] LastPhase = PhaseWidth'(FrameBytes);

  // fixed frame head byte
  localparam logic [7:0] FrameHead = 8'h19;

  // rolling code chain constants
  localparam logic [7:0] CodeAdd0 = 8'hDA;
  localparam logic [7:0] CodeXor0 = 8'hBE;
  localparam logic [7:0] CodeAdd1 = 8'hBF;
  localparam logic [7:0] CodeXor1 = 8'h1A;
  localparam logic [7:0] CodeXor2 = 8'h3A;
  localparam logic [7:0] CodeAdd2 = 8'hCB;
  localparam logic [7:0] CodeXor3 = 8'h2F;

  // configuration register reset values
  localparam logic [15:0] ShortReset = 16'd500;
  localparam logic [15:0] LongReset = 16'd1000;
  localparam logic [15:0] SyncReset = 16'd15000;
  localparam logic [19:0] RepeatReset = 20'd1000000;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegFixedOneTwo   = 3'd0,
    RegCodedThreeFive = 3'd1,
    RegFixedSix      = 3'd2,
    RegCodedSevenTen = 3'd3,
    RegShort         = 3'd4,
    RegLong          = 3'd5,
    RegSync          = 3'd6,
    RegRepeat        = 3'd7
  } cfg_reg_t;

  typedef logic [TimerWidth-1:0] timer_t;

  // 7-bit rolling code from the freshly bumped sequence counter
  function automatic logic [6:0] rolling_code(input logic [15:0] seq);
    logic [7:0] c;
    c = seq[7:0] + CodeAdd0;
    c = c ^ CodeXor0;
    c = c + CodeAdd1;
    c = c ^ CodeXor1;
    c = c + {4'h0, seq[11:8]};
    c = c ^ CodeXor2;
    c = c + CodeAdd2;
    c = c ^ CodeXor3;
    return c[6:0];
  endfunction

  // segment length: zero counts as one, clamp to the timer range
  function automatic timer_t limit_of(input logic [31:0] len);
    timer_t r;
    if (len == 32'd0) begin
      r = timer_t'(1);
    end else if (len > TimerMax) begin
      r = TimerMax[TimerWidth-1:0];
    end else begin
      r = len[TimerWidth-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rolling_code_pulse_width_transmitter.sv @@
`default_nettype none

// channel   signals                             direction  notes
// input     in_valid, in_ready, tick            in         one tick flag per word
// output    out_valid, out_ready, line_level,   out        one word per input word
//           busy_res, frame_start, sequence_number
// config    cfg_write_en, cfg_index, cfg_data   in         write only, no wait
//
// one input word is taken every clock unless the output stalls; its result sits in
// the output register on the next cycle, so throughput is one word per clock when
// not stalled, set by the single register stage holding the transmitter state
// a stalled result stays in the output register; a new word is taken whenever
// that register is empty or being emptied in the same cycle
// reset clears all control state and the configuration registers; the frame
// byte store is not cleared and is only read after a frame has been built

module rolling_code_pulse_width_transmitter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        tick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             line_level,
  output logic             busy_res,
  output logic             frame_start,
  output logic [15:0]      sequence_number,
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration registers
  logic [15:0] fixed_bytes_one_two;
  logic [23:0] coded_bytes_three_to_five;
  logic [7:0]  fixed_byte_six;
  logic [31:0] coded_bytes_seven_to_ten;
  logic [15:0] short_ticks;
  logic [15:0] long_ticks;
  logic [15:0] sync_low_ticks;
  logic [19:0] repeat_ticks;

  // transmitter state
  logic [15:0]                     sequence_counter, sequence_counter_next;
  logic [7:0]                      frame_store [rcpw_pkg::FrameBytes];
  logic [rcpw_pkg::PhaseWidth-1:0] send_phase, send_phase_next;
  logic [1:0]                      edge_index, edge_index_next;
  logic [2:0]                      bit_index, bit_index_next;
  logic                            busy_flag, busy_flag_next;
  rcpw_pkg::timer_t                duration_counter, duration_counter_next;
  logic                            line_register, line_register_next;
  logic                            started;

  // frame building
  logic [15:0]                       seq_inc;
  logic [6:0]                        code;
  logic [7:0]                        frame_new [rcpw_pkg::FrameBytes];
  logic                              build;
  logic [rcpw_pkg::ByteIdxWidth-1:0] byte_sel;
  logic [7:0]                        cur_byte;
  logic                              cur_bit;
  logic [15:0]                       seg_raw;
  rcpw_pkg::timer_t                  seg_len;
  rcpw_pkg::timer_t                  dc_inc;
  logic                              stray;
  logic                              accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_bytes_one_two       <= '0;
      coded_bytes_three_to_five <= '0;
      fixed_byte_six            <= '0;
      coded_bytes_seven_to_ten  <= '0;
      short_ticks               <= rcpw_pkg::ShortReset;
      long_ticks                <= rcpw_pkg::LongReset;
      sync_low_ticks            <= rcpw_pkg::SyncReset;
      repeat_ticks              <= rcpw_pkg::RepeatReset;
    end else if (cfg_write_en) begin
      unique case (rcpw_pkg::cfg_reg_t'(cfg_index))
        rcpw_pkg::RegFixedOneTwo:    fixed_bytes_one_two       <= cfg_data[15:0];
        rcpw_pkg::RegCodedThreeFive: coded_bytes_three_to_five <= cfg_data[23:0];
        rcpw_pkg::RegFixedSix:       fixed_byte_six            <= cfg_data[7:0];
        rcpw_pkg::RegCodedSevenTen:  coded_bytes_seven_to_ten  <= cfg_data;
        rcpw_pkg::RegShort:          short_ticks               <= cfg_data[15:0];
        rcpw_pkg::RegLong:           long_ticks                <= cfg_data[15:0];
        rcpw_pkg::RegSync:           sync_low_ticks            <= cfg_data[15:0];
        rcpw_pkg::RegRepeat:         repeat_ticks              <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  // new frame bytes from the bumped counter
  always_comb begin
    logic [7:0] x;
    seq_inc = sequence_counter + 16'd1;
    code = rcpw_pkg::rolling_code(seq_inc);
    frame_new[0]  = rcpw_pkg::FrameHead;
    frame_new[1]  = fixed_bytes_one_two[15:8];
    frame_new[2]  = fixed_bytes_one_two[7:0];
    frame_new[3]  = coded_bytes_three_to_five[23:16] + {1'b0, code};
    frame_new[4]  = coded_bytes_three_to_five[15:8] + {1'b0, code};
    frame_new[5]  = coded_bytes_three_to_five[7:0] + {1'b0, code};
    frame_new[6]  = fixed_byte_six;
    frame_new[7]  = coded_bytes_seven_to_ten[31:24] + {1'b0, code};
    frame_new[8]  = coded_bytes_seven_to_ten[23:16] + {1'b0, code};
    frame_new[9]  = coded_bytes_seven_to_ten[15:8] + {1'b0, code};
    frame_new[10] = coded_bytes_seven_to_ten[7:0] + {1'b0, code};
    x = '0;
    for (int k = 0; k < rcpw_pkg::PayloadBytes; k++) begin
      x = x ^ frame_new[k];
    end
    frame_new[rcpw_pkg::PayloadBytes] = x;
  end

  // current bit and segment length
  always_comb begin
    logic [rcpw_pkg::PhaseWidth-1:0] ph_m1;
    ph_m1 = send_phase - rcpw_pkg::PhaseWidth'(1);
    if (send_phase == '0 || send_phase > rcpw_pkg::LastPhase) begin
      byte_sel = '0;
    end else begin
      byte_sel = ph_m1[rcpw_pkg::ByteIdxWidth-1:0];
    end
    cur_byte = frame_store[byte_sel];
    cur_bit  = cur_byte[~bit_index];
    if (send_phase == '0) begin
      seg_raw = (edge_index == 2'd1) ? sync_low_ticks : short_ticks;
    end else if (edge_index == 2'd0) begin
      seg_raw = cur_bit ? long_ticks : short_ticks;
    end else begin
      seg_raw = cur_bit ? short_ticks : long_ticks;
    end
    seg_len = rcpw_pkg::limit_of({16'd0, seg_raw});
    stray = (send_phase > rcpw_pkg::LastPhase) ||
            (send_phase == '0 && edge_index > 2'd2) ||
            (send_phase != '0 && edge_index > 2'd1);
  end

  // next state for one accepted word
  always_comb begin
    sequence_counter_next = sequence_counter;
    send_phase_next       = send_phase;
    edge_index_next       = edge_index;
    bit_index_next        = bit_index;
    busy_flag_next        = busy_flag;
    duration_counter_next = duration_counter;
    line_register_next    = line_register;
    started               = 1'b0;
    build                 = 1'b0;
    if ({{(32 - rcpw_pkg::TimerWidth){1'b0}}, duration_counter} < rcpw_pkg::TimerMax) begin
      dc_inc = duration_counter + rcpw_pkg::timer_t'(1);
    end else begin
      dc_inc = duration_counter;
    end
    if (accept && tick) begin
      duration_counter_next = dc_inc;
      if (!busy_flag) begin
        // idle wait, then build a frame
        if (dc_inc >= rcpw_pkg::limit_of({12'd0, repeat_ticks})) begin
          build                 = 1'b1;
          started               = 1'b1;
          sequence_counter_next = seq_inc;
          busy_flag_next        = 1'b1;
          send_phase_next       = '0;
          edge_index_next       = '0;
          bit_index_next        = '0;
          duration_counter_next = '0;
          line_register_next    = 1'b1;
        end
      end else if (stray) begin
        busy_flag_next        = 1'b0;
        send_phase_next       = '0;
        edge_index_next       = '0;
        bit_index_next        = '0;
        line_register_next    = 1'b0;
        duration_counter_next = '0;
      end else if (dc_inc >= seg_len) begin
        duration_counter_next = '0;
        if (send_phase == '0) begin
          // preamble: high short, low sync, high short
          if (edge_index < 2'd2) begin
            edge_index_next    = edge_index + 2'd1;
            line_register_next = (edge_index != 2'd0);
          end else begin
            edge_index_next    = '0;
            send_phase_next    = rcpw_pkg::PhaseWidth'(1);
            bit_index_next     = '0;
            line_register_next = 1'b0;
          end
        end else if (edge_index == 2'd0) begin
          edge_index_next    = 2'd1;
          line_register_next = 1'b1;
        end else begin
          // bit done, step to next bit or byte
          edge_index_next    = '0;
          line_register_next = 1'b0;
          if (bit_index < 3'd7) begin
            bit_index_next = bit_index + 3'd1;
          end else begin
            bit_index_next  = '0;
            send_phase_next = send_phase + rcpw_pkg::PhaseWidth'(1);
            if (send_phase == rcpw_pkg::LastPhase) begin
              busy_flag_next  = 1'b0;
              send_phase_next = '0;
            end
          end
        end
      end
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter <= '0;
      send_phase       <= '0;
      edge_index       <= '0;
      bit_index        <= '0;
      busy_flag        <= 1'b0;
      duration_counter <= '0;
      line_register    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      sequence_counter <= sequence_counter_next;
      send_phase       <= send_phase_next;
      edge_index       <= edge_index_next;
      bit_index        <= bit_index_next;
      busy_flag        <= busy_flag_next;
      duration_counter <= duration_counter_next;
      line_register    <= line_register_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload and frame bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      line_level      <= line_register_next;
      busy_res        <= busy_flag_next;
      frame_start     <= started;
      sequence_number <= sequence_counter_next;
    end
    if (build) begin
      for (int k = 0; k < rcpw_pkg::FrameBytes; k++) begin
        frame_store[k] <= frame_new[k];
      end
    end
  end

  // checks
  a_start_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_start |-> busy_res && line_level)
    else $error("frame start without busy high line");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> send_phase == '0 && edge_index == '0 && bit_index == '0)
    else $error("idle with stale sequencer state");

  a_no_tick_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !tick |=> $stable(sequence_counter) && $stable(busy_flag) &&
      $stable(duration_counter) && $stable(line_register))
    else $error("state moved without a tick");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    busy_flag |-> send_phase <= rcpw_pkg::LastPhase)
    else $error("send phase beyond frame");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
module tb;

  // one predicted or observed output word
  typedef struct packed {
    logic        line_lvl;
    logic        busy;
    logic        start;
    logic [15:0] seq;
  } tx_word_t;

  localparam int QuietLimit = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               tick = 1'b0;
  logic               out_ready = 1'b0;
  logic               cfg_write_en = 1'b0;
  rcpw_pkg::cfg_reg_t cfg_index = rcpw_pkg::RegFixedOneTwo;
  logic [31:0]        cfg_data = 32'd0;
  logic               in_ready;
  logic               out_valid;
  logic               line_level;
  logic               busy_res;
  logic               frame_start;
  logic [15:0]        sequence_number;

  rolling_code_pulse_width_transmitter uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .tick(tick),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .line_level(line_level),
    .busy_res(busy_res),
    .frame_start(frame_start),
    .sequence_number(sequence_number),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ticks waiting to be sent and line words waiting to be seen
  logic     tick_queue[$];
  tx_word_t expected_words[$];
  tx_word_t oldest_word;
  int       fail_count = 0;
  int       quiet_cycles = 0;
  int       sender_idle_pct = 26;
  int       receiver_idle_pct = 75;
  logic [31:0] cfg_plan [8];

  // transmitter settings as the block should hold them
  logic [15:0] cfg_one_two = 16'd0;
  logic [23:0] cfg_three_five = 24'd0;
  logic [7:0]  cfg_six = 8'd0;
  logic [31:0] cfg_seven_ten = 32'd0;
  logic [15:0] cfg_short = 16'd500;
  logic [15:0] cfg_long = 16'd1000;
  logic [15:0] cfg_sync = 16'd15000;
  logic [19:0] cfg_repeat = 20'd1000000;

  // transmitter state
  logic [15:0]      seq_q = 16'd0;
  logic [7:0]       frame_bytes [12];
  logic [3:0]       phase_q = 4'd0;
  logic [1:0]       seg_q = 2'd0;
  logic [2:0]       bit_q = 3'd0;
  logic             busy_q = 1'b0;
  rcpw_pkg::timer_t dur_q = '0;
  logic             line_q = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // zero counts as one tick, anything past the timer is clamped
  function automatic rcpw_pkg::timer_t ticks_for(input logic [31:0] len);
    if (len == 32'd0) return rcpw_pkg::timer_t'(1);
    if (len > rcpw_pkg::TimerMax) return rcpw_pkg::TimerMax[rcpw_pkg::TimerWidth-1:0];
    return len[rcpw_pkg::TimerWidth-1:0];
  endfunction

  // 7-bit rolling code from the bumped sequence count
  function automatic logic [6:0] roll_code(input logic [15:0] count);
    logic [7:0] c;
    c = count[7:0] + 8'hDA;
    c = c ^ 8'hBE;
    c = c + 8'hBF;
    c = c ^ 8'h1A;
    c = c + {4'h0, count[11:8]};
    c = c ^ 8'h3A;
    c = c + 8'hCB;
    c = c ^ 8'h2F;
    return c[6:0];
  endfunction

  // advance the transmitter by one word and give the line word it shows
  function automatic tx_word_t step_transmitter(input logic tk);
    tx_word_t         r;
    logic             started;
    logic             cur_bit;
    rcpw_pkg::timer_t seg;
    logic [6:0]       code;
    logic [7:0]       x;
    int               k;
    started = 1'b0;
    if (tk) begin
      if (dur_q < rcpw_pkg::TimerMax[rcpw_pkg::TimerWidth-1:0]) dur_q = dur_q + 1'b1;
      if (!busy_q) begin
        // idle wait over: build a new frame and start the preamble
        if (dur_q >= ticks_for(32'(cfg_repeat))) begin
          seq_q = seq_q + 16'd1;
          code = roll_code(seq_q);
          frame_bytes[0] = 8'h19;
          frame_bytes[1] = cfg_one_two[15:8];
          frame_bytes[2] = cfg_one_two[7:0];
          for (k = 0; k < 3; k++) frame_bytes[3 + k] = cfg_three_five[(23 - 8 * k) -: 8] + code;
          frame_bytes[6] = cfg_six;
          for (k = 0; k < 4; k++) frame_bytes[7 + k] = cfg_seven_ten[(31 - 8 * k) -: 8] + code;
          x = 8'd0;
          for (k = 0; k < 11; k++) x = x ^ frame_bytes[k];
          frame_bytes[11] = x;
          busy_q = 1'b1;
          phase_q = 4'd0;
          seg_q = 2'd0;
          bit_q = 3'd0;
          dur_q = '0;
          line_q = 1'b1;
          started = 1'b1;
        end
      end else if (phase_q > 4'd12 || (phase_q == 4'd0 && seg_q > 2'd2) ||
                   (phase_q != 4'd0 && seg_q > 2'd1)) begin
        // stray phase ends the frame
        busy_q = 1'b0;
        phase_q = 4'd0;
        seg_q = 2'd0;
        bit_q = 3'd0;
        line_q = 1'b0;
        dur_q = '0;
      end else begin
        if (phase_q == 4'd0) begin
          seg = (seg_q == 2'd1) ? ticks_for(32'(cfg_sync)) : ticks_for(32'(cfg_short));
        end else begin
          cur_bit = frame_bytes[phase_q - 4'd1][3'd7 - bit_q];
          if (seg_q == 2'd0) seg = ticks_for(32'(cur_bit ? cfg_long : cfg_short));
          else seg = ticks_for(32'(cur_bit ? cfg_short : cfg_long));
        end
        // segment done: move on, new level visible at once
        if (dur_q >= seg) begin
          dur_q = '0;
          if (phase_q == 4'd0) begin
            if (seg_q < 2'd2) begin
              seg_q = seg_q + 2'd1;
              line_q = (seg_q == 2'd1) ? 1'b0 : 1'b1;
            end else begin
              seg_q = 2'd0;
              phase_q = 4'd1;
              bit_q = 3'd0;
              line_q = 1'b0;
            end
          end else if (seg_q == 2'd0) begin
            seg_q = 2'd1;
            line_q = 1'b1;
          end else begin
            seg_q = 2'd0;
            line_q = 1'b0;
            if (bit_q < 3'd7) begin
              bit_q = bit_q + 3'd1;
            end else begin
              bit_q = 3'd0;
              phase_q = phase_q + 4'd1;
              if (phase_q > 4'd12) begin
                busy_q = 1'b0;
                phase_q = 4'd0;
                seg_q = 2'd0;
                bit_q = 3'd0;
                line_q = 1'b0;
              end
            end
          end
        end
      end
    end
    r.line_lvl = line_q;
    r.busy = busy_q;
    r.start = started;
    r.seq = seq_q;
    return r;
  endfunction

  // write all eight registers from cfg_plan, one per clock
  task automatic apply_config;
    int i;
    for (i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_write_en <= 1'b1;
      cfg_index <= rcpw_pkg::cfg_reg_t'(i);
      cfg_data <= cfg_plan[i];
      case (rcpw_pkg::cfg_reg_t'(i))
        rcpw_pkg::RegFixedOneTwo:    cfg_one_two = cfg_plan[i][15:0];
        rcpw_pkg::RegCodedThreeFive: cfg_three_five = cfg_plan[i][23:0];
        rcpw_pkg::RegFixedSix:       cfg_six = cfg_plan[i][7:0];
        rcpw_pkg::RegCodedSevenTen:  cfg_seven_ten = cfg_plan[i];
        rcpw_pkg::RegShort:          cfg_short = cfg_plan[i][15:0];
        rcpw_pkg::RegLong:           cfg_long = cfg_plan[i][15:0];
        rcpw_pkg::RegSync:           cfg_sync = cfg_plan[i][15:0];
        rcpw_pkg::RegRepeat:         cfg_repeat = cfg_plan[i][19:0];
        default: ;
      endcase
    end
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // wait until every tick is sent and every line word seen, sampled mid-cycle
  task automatic wait_drain;
    while (tick_queue.size() != 0 || in_valid || expected_words.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h got %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(step_transmitter(tick));
      if (!in_valid || in_ready) begin
        if (tick_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          tick <= tick_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: line %0b busy %0b start %0b seq %0h", $time,
                   line_level, busy_res, frame_start, sequence_number);
          fail_count++;
        end else begin
          oldest_word = expected_words.pop_front();
          check_field("line_level", 16'(oldest_word.line_lvl), 16'(line_level));
          check_field("busy_res", 16'(oldest_word.busy), 16'(busy_res));
          check_field("frame_start", 16'(oldest_word.start), 16'(frame_start));
          check_field("sequence_number", oldest_word.seq, sequence_number);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int n;
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: long idle wait, no frame may start
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    wait_drain();

    // all-ones bytes and zero lengths: frame on the first tick, one-tick segments
    cfg_plan = '{32'h0000_FFFF, 32'h00FF_FFFF, 32'h0000_00FF, 32'hFFFF_FFFF,
                 32'd0, 32'd0, 32'd0, 32'd0};
    apply_config();
    for (i = 0; i < 21; i++) tick_queue.push_back(i != 5 && i != 12);
    wait_drain();

    // random phases, short segments so plenty of frames go out
    for (p = 0; p < 9; p++) begin
      if (p == 3) begin
        sender_idle_pct = 75;
        receiver_idle_pct = 26;
      end else if (p == 6) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      for (i = 0; i < 4; i++) cfg_plan[i] = (p == 1) ? 32'd0 : $urandom;
      if (p == 4) begin
        // largest lengths: frame in progress stalls, idle wait never ends here
        cfg_plan[rcpw_pkg::RegShort] = {16'($urandom), 16'hFFFF};
        cfg_plan[rcpw_pkg::RegLong] = {16'($urandom), 16'hFFFF};
        cfg_plan[rcpw_pkg::RegSync] = {16'($urandom), 16'hFFFF};
        cfg_plan[rcpw_pkg::RegRepeat] = {12'($urandom), 20'hFFFFF};
      end else begin
        cfg_plan[rcpw_pkg::RegShort] = {16'($urandom), 16'($urandom_range(0, 3))};
        cfg_plan[rcpw_pkg::RegLong] = {16'($urandom), 16'($urandom_range(0, 3))};
        cfg_plan[rcpw_pkg::RegSync] = {16'($urandom), 16'($urandom_range(0, 4))};
        cfg_plan[rcpw_pkg::RegRepeat] = {12'($urandom), 20'((p == 7) ? $urandom_range(20, 80)
                                                                      : $urandom_range(0, 6))};
      end
      apply_config();
      n = (p == 4) ? 60 : 170;
      for (i = 0; i < n; i++) tick_queue.push_back($urandom_range(0, 9) != 0);
      wait_drain();
    end

    repeat (4) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t %0d expected words never arrived", $time, expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rcpw_pkg.sv
hdl/rolling_code_pulse_width_transmitter.sv
verif/tb.sv
